@@ design/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros used by the ray-cast unit design file.
// Every macro checks on the rising edge of i_clk and is held off in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold on every clock edge.
`define PIP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Antecedent in this cycle implies the consequent in the next one.
`define PIP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/pip_pkg.sv @@
// ---------------------------------------------------------------------------
// pip_pkg
// Types and constants for the point-in-polygon crossing-number unit.
// ---------------------------------------------------------------------------
package pip_pkg;

    // Polygon size the count saturation is sized for
    localparam int MAX_VERTICES = 1024;

    // Saturation limit of the crossing count: twice the vertex budget, capped
    localparam int COUNT_LIMIT_INT = (2 * MAX_VERTICES > 4095) ? 4095 : 2 * MAX_VERTICES;
    localparam int COUNT_W         = 12;
    localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(COUNT_LIMIT_INT);

    // Left reach of the ray, in whole units; fraction bits of Q16.16
    localparam int REACH_INT = 9999;
    localparam int FRAC_BITS = 16;
    localparam logic signed [15:0] REACH_Q = 16'(REACH_INT);

    // Input word: query point and one vertex
    typedef struct packed {
        logic signed [31:0] query_x;
        logic signed [31:0] query_y;
        logic signed [31:0] vertex_x;
        logic signed [31:0] vertex_y;
        logic               first_vertex;
        logic               last_vertex;
    } t_pip_in;

    // Output word: inside flag and saturated crossing count
    typedef struct packed {
        logic               inside_res;
        logic [COUNT_W-1:0] left_crossings;
    } t_pip_out;

endpackage

@@ design/point_in_polygon_ray_cast_unit.sv @@
// ---------------------------------------------------------------------------
// point_in_polygon_ray_cast_unit
// Streaming crossing-number point-in-polygon test with a five-stage
// edge pipeline and a saturating crossing counter.
// ---------------------------------------------------------------------------

// Takes one vertex word per clock cycle, back to back, with the query point
// carried in every word. Each word tests the edge from the previous vertex
// (unless marked first) and, when marked last, the closing edge to the first
// vertex; both edges run side by side through the same five stages (capture,
// order and difference, multiply, sum, sign test), so the rate is one word a
// cycle unless stalled, and a last word's result is loaded into the output
// register from the sign test stage. The count and parity are updated in
// order at the pipeline tail. A pending result only stalls the pipeline when
// another last word reaches the tail; other words keep flowing. inside_res is
// the parity of the exact crossing count; left_crossings saturates at 2048.

`include "assert_macros.svh"

module point_in_polygon_ray_cast_unit
    import pip_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_pip_in  i_in_word,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_pip_out o_out_word
);

    // One edge, as stored at the input stage
    typedef struct packed {
        logic signed [31:0] x1;
        logic signed [31:0] y1;
        logic signed [31:0] x2;
        logic signed [31:0] y2;
    } t_edge;

    // Edge ordered by rising y, with differences to the query point
    typedef struct packed {
        logic               ok;
        logic signed [32:0] a;
        logic signed [32:0] b;
        logic signed [32:0] c;
        logic signed [32:0] d;
        logic signed [32:0] dy;
    } t_prep;

    typedef struct packed {
        logic               ok;
        logic signed [65:0] p1;
        logic signed [65:0] p2;
        logic signed [47:0] pr;
    } t_prod;

    typedef struct packed {
        logic               ok;
        logic signed [66:0] dsum;
        logic signed [63:0] reach;
    } t_sum;

    // Order the edge, check y span and form the cross-product operands
    function automatic t_prep prep_edge(input t_edge e, input logic en,
                                        input logic signed [31:0] qx,
                                        input logic signed [31:0] qy);
        t_prep              p;
        logic signed [31:0] xlo;
        logic signed [31:0] ylo;
        logic signed [31:0] xhi;
        logic signed [31:0] yhi;
        if (e.y1 > e.y2) begin
            xlo = e.x2; ylo = e.y2; xhi = e.x1; yhi = e.y1;
        end else begin
            xlo = e.x1; ylo = e.y1; xhi = e.x2; yhi = e.y2;
        end
        p.ok = en && (e.y1 != e.y2) && (qy >= ylo) && (qy <= yhi);
        p.a  = 33'(xlo) - 33'(qx);
        p.b  = 33'(yhi) - 33'(qy);
        p.c  = 33'(xhi) - 33'(qx);
        p.d  = 33'(qy) - 33'(ylo);
        p.dy = 33'(yhi) - 33'(ylo);
        return p;
    endfunction

    function automatic t_prod mul_edge(input t_prep p);
        t_prod m;
        m.ok = p.ok;
        m.p1 = 66'(p.a) * 66'(p.b);
        m.p2 = 66'(p.c) * 66'(p.d);
        m.pr = 48'(p.dy) * 48'(REACH_Q);
        return m;
    endfunction

    function automatic t_sum sum_edge(input t_prod m);
        t_sum s;
        s.ok    = m.ok;
        s.dsum  = 67'(m.p1) + 67'(m.p2);
        s.reach = {m.pr, {FRAC_BITS{1'b0}}};
        return s;
    endfunction

    // Crossing when the x offset is negative but within the left reach
    function automatic logic cross_edge(input t_sum s);
        logic signed [67:0] e;
        e = 68'(s.dsum) + 68'(s.reach);
        return s.ok && s.dsum[66] && !e[67];
    endfunction

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c,
                                                   input logic hit);
        logic [COUNT_W-1:0] r;
        r = c;
        if (hit && (c < COUNT_LIMIT)) begin
            r = c + COUNT_W'(1);
        end
        return r;
    endfunction

    // Polygon state
    logic signed [31:0] r_start_x, r_start_y, r_prior_x, r_prior_y;
    logic [COUNT_W-1:0] r_count;
    logic               r_parity;

    // Pipeline stage registers
    logic               r_s1_valid, r_s2_valid, r_s3_valid, r_s4_valid, r_s5_valid;
    logic               r_s1_first, r_s2_first, r_s3_first, r_s4_first, r_s5_first;
    logic               r_s1_last,  r_s2_last,  r_s3_last,  r_s4_last,  r_s5_last;
    logic signed [31:0] r_s1_qx, r_s1_qy;
    t_edge              r_s1_ea, r_s1_eb;
    t_prep              r_s2_ea, r_s2_eb;
    t_prod              r_s3_ea, r_s3_eb;
    t_sum               r_s4_ea, r_s4_eb;
    logic               r_s5_xa, r_s5_xb;

    // Output register
    logic               r_out_valid;
    t_pip_out           r_out_word;

    // Stage flow control
    logic w_out_free, w_take5, w_load1, w_load2, w_load3, w_load4, w_load5;
    logic w_in_take;
    logic [COUNT_W-1:0] n_count;
    logic               n_parity;

    // A stage loads when it is empty or its word moves on
    always_comb begin
        w_out_free = !r_out_valid || i_out_ready;
        w_take5    = r_s5_valid && (!r_s5_last || w_out_free);
        w_load5    = !r_s5_valid || w_take5;
        w_load4    = !r_s4_valid || w_load5;
        w_load3    = !r_s3_valid || w_load4;
        w_load2    = !r_s2_valid || w_load3;
        w_load1    = !r_s1_valid || w_load2;
        w_in_take  = i_in_valid && w_load1;
    end

    assign o_in_ready  = w_load1;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // Start and previous vertex, written as each word is accepted
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_x <= '0;
            r_start_y <= '0;
            r_prior_x <= '0;
            r_prior_y <= '0;
        end else if (w_in_take) begin
            if (i_in_word.first_vertex) begin
                r_start_x <= i_in_word.vertex_x;
                r_start_y <= i_in_word.vertex_y;
            end
            r_prior_x <= i_in_word.vertex_x;
            r_prior_y <= i_in_word.vertex_y;
        end
    end

    // Valid bits of the pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
            r_s5_valid <= 1'b0;
        end else begin
            if (w_load1) r_s1_valid <= i_in_valid;
            if (w_load2) r_s2_valid <= r_s1_valid;
            if (w_load3) r_s3_valid <= r_s2_valid;
            if (w_load4) r_s4_valid <= r_s3_valid;
            if (w_load5) r_s5_valid <= r_s4_valid;
        end
    end

    // Stage 1: capture the word and both candidate edges
    always_ff @(posedge i_clk) begin
        if (w_load1) begin
            r_s1_qx    <= i_in_word.query_x;
            r_s1_qy    <= i_in_word.query_y;
            r_s1_first <= i_in_word.first_vertex;
            r_s1_last  <= i_in_word.last_vertex;
            r_s1_ea    <= '{x1: r_prior_x, y1: r_prior_y,
                            x2: i_in_word.vertex_x, y2: i_in_word.vertex_y};
            r_s1_eb.x1 <= i_in_word.vertex_x;
            r_s1_eb.y1 <= i_in_word.vertex_y;
            r_s1_eb.x2 <= i_in_word.first_vertex ? i_in_word.vertex_x : r_start_x;
            r_s1_eb.y2 <= i_in_word.first_vertex ? i_in_word.vertex_y : r_start_y;
        end
    end

    // Stages 2 to 5: order, multiply, sum, sign test
    always_ff @(posedge i_clk) begin
        if (w_load2) begin
            r_s2_first <= r_s1_first;
            r_s2_last  <= r_s1_last;
            r_s2_ea    <= prep_edge(r_s1_ea, !r_s1_first, r_s1_qx, r_s1_qy);
            r_s2_eb    <= prep_edge(r_s1_eb, r_s1_last, r_s1_qx, r_s1_qy);
        end
        if (w_load3) begin
            r_s3_first <= r_s2_first;
            r_s3_last  <= r_s2_last;
            r_s3_ea    <= mul_edge(r_s2_ea);
            r_s3_eb    <= mul_edge(r_s2_eb);
        end
        if (w_load4) begin
            r_s4_first <= r_s3_first;
            r_s4_last  <= r_s3_last;
            r_s4_ea    <= sum_edge(r_s3_ea);
            r_s4_eb    <= sum_edge(r_s3_eb);
        end
        if (w_load5) begin
            r_s5_first <= r_s4_first;
            r_s5_last  <= r_s4_last;
            r_s5_xa    <= cross_edge(r_s4_ea);
            r_s5_xb    <= cross_edge(r_s4_eb);
        end
    end

    // Count update: clear on first, then the edge and the closing edge
    always_comb begin
        n_count  = r_s5_first ? '0 : r_count;
        n_parity = r_s5_first ? 1'b0 : r_parity;
        n_count  = sat_inc(n_count, r_s5_xa);
        n_count  = sat_inc(n_count, r_s5_xb);
        n_parity = n_parity ^ r_s5_xa ^ r_s5_xb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_parity <= 1'b0;
        end else if (w_take5) begin
            r_count  <= n_count;
            r_parity <= n_parity;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take5 && r_s5_last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take5 && r_s5_last) begin
            r_out_word.inside_res     <= n_parity;
            r_out_word.left_crossings <= n_count;
        end
    end

    // Checks
    `PIP_ASSERT(a_count_limit, o_out_valid |-> (o_out_word.left_crossings <= COUNT_LIMIT), "crossing count above limit")
    `PIP_ASSERT(a_parity_match, (o_out_valid && (o_out_word.left_crossings < COUNT_LIMIT)) |-> (o_out_word.inside_res == o_out_word.left_crossings[0]), "parity disagrees with unsaturated count")
    `PIP_ASSERT(a_stall_cause, !o_in_ready |-> (o_out_valid && !i_out_ready), "input stalled without a pending result")
    `PIP_ASSERT_NEXT(a_result_load, (w_take5 && r_s5_last), o_out_valid, "last word did not produce a result")

endmodule
